@@ rtl/bbgp_pkg.sv @@
`timescale 1ns / 1ps
package bbgp_pkg;

	localparam int POS_W  = 18;
	localparam int LEN_W  = 17;
	localparam int FB_W   = 15;
	localparam int RATE_W = 16;
	localparam int EFF_W  = 3;
	localparam int GAIN_W = 15;

	localparam logic [EFF_W-1:0] EFF_BYPASS  = 3'd0;
	localparam logic [EFF_W-1:0] EFF_STUTTER = 3'd1;
	localparam logic [EFF_W-1:0] EFF_REVERSE = 3'd2;
	localparam logic [EFF_W-1:0] EFF_STRETCH = 3'd3;
	localparam logic [EFF_W-1:0] EFF_GATE    = 3'd4;
	localparam logic [EFF_W-1:0] EFF_ECHO    = 3'd5;

	localparam logic [2:0] REG_STEP_LENGTH   = 3'd0;
	localparam logic [2:0] REG_STUTTER_LOOP  = 3'd1;
	localparam logic [2:0] REG_GATE_CHOP     = 3'd2;
	localparam logic [2:0] REG_GATE_DUTY     = 3'd3;
	localparam logic [2:0] REG_ECHO_DELAY    = 3'd4;
	localparam logic [2:0] REG_ECHO_FEEDBACK = 3'd5;
	localparam logic [2:0] REG_STRETCH_RATE  = 3'd6;

	localparam logic [LEN_W-1:0]  RST_STEP_LENGTH   = 17'd24000;
	localparam logic [LEN_W-1:0]  RST_STUTTER_LOOP  = 17'd12000;
	localparam logic [LEN_W-1:0]  RST_GATE_CHOP     = 17'd1500;
	localparam logic [LEN_W-1:0]  RST_GATE_DUTY     = 17'd750;
	localparam logic [LEN_W-1:0]  RST_ECHO_DELAY    = 17'd6000;
	localparam logic [FB_W-1:0]   RST_ECHO_FEEDBACK = 15'd19661;
	localparam logic [RATE_W-1:0] RST_STRETCH_RATE  = 16'd26214;

	// 0.65 and 0.55 in unsigned Q0.15
	localparam logic [GAIN_W-1:0] GAIN_DRY = 15'd21299;
	localparam logic [GAIN_W-1:0] GAIN_WET = 15'd18022;

	typedef struct packed {
		logic [LEN_W-1:0]  step_length;
		logic [LEN_W-1:0]  stutter_loop;
		logic [LEN_W-1:0]  gate_chop;
		logic [LEN_W-1:0]  gate_duty;
		logic [LEN_W-1:0]  echo_delay;
		logic [FB_W-1:0]   echo_feedback;
		logic [RATE_W-1:0] stretch_rate;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic div_start;
		logic rd_sel;
		logic cap0;
		logic cap1;
		logic mul_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/beat_buffer_glitch_player.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Signals                         Content
// s_*       in   s_tvalid s_tready s_tdata s_tuser   one stereo sample, step flag, effect
// m_*       out  m_tvalid m_tready m_tdata           one processed stereo sample
// apb       in   psel penable pwrite paddr pwdata    effect settings, read back on prdata
//
// Each sample is worked through before the next is accepted; stutter and gate
// also wait on the shared remainder unit. The capture memory read port (two
// reads per sample) and the remainder unit set the pace. Reset is asynchronous,
// active low; the capture memory needs no clearing pass, a fill mark makes
// unwritten entries read zero.
// A stalled output holds its result while the next sample is taken and worked.
module beat_buffer_glitch_player #(
	parameter int CAPTURE_DEPTH = 262144,
	parameter int SAMPLE_BITS   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// left_in, right_in (zero pad to bytes)
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// new_step, effect[2:0]
	input  logic [3:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// left_out, right_out (zero pad to bytes)
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int SB  = SAMPLE_BITS;
	localparam int TDW = ((2*SAMPLE_BITS+7)/8)*8;

	bbgp_pkg::cfg_t cfg_q;
	bbgp_pkg::cmd_t cmd;
	bbgp_pkg::sts_t sts;
	logic           wr_en;
	logic [2:0]     reg_idx;
	logic [SB-1:0]  out_l, out_r;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	// a write transfer lands in the access phase
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_length   <= bbgp_pkg::RST_STEP_LENGTH;
			cfg_q.stutter_loop  <= bbgp_pkg::RST_STUTTER_LOOP;
			cfg_q.gate_chop     <= bbgp_pkg::RST_GATE_CHOP;
			cfg_q.gate_duty     <= bbgp_pkg::RST_GATE_DUTY;
			cfg_q.echo_delay    <= bbgp_pkg::RST_ECHO_DELAY;
			cfg_q.echo_feedback <= bbgp_pkg::RST_ECHO_FEEDBACK;
			cfg_q.stretch_rate  <= bbgp_pkg::RST_STRETCH_RATE;
		end else if (wr_en) begin
			case (reg_idx)
				bbgp_pkg::REG_STEP_LENGTH:   cfg_q.step_length   <= pwdata[16:0];
				bbgp_pkg::REG_STUTTER_LOOP:  cfg_q.stutter_loop  <= pwdata[16:0];
				bbgp_pkg::REG_GATE_CHOP:     cfg_q.gate_chop     <= pwdata[16:0];
				bbgp_pkg::REG_GATE_DUTY:     cfg_q.gate_duty     <= pwdata[16:0];
				bbgp_pkg::REG_ECHO_DELAY:    cfg_q.echo_delay    <= pwdata[16:0];
				bbgp_pkg::REG_ECHO_FEEDBACK: cfg_q.echo_feedback <= pwdata[14:0];
				bbgp_pkg::REG_STRETCH_RATE:  cfg_q.stretch_rate  <= pwdata[15:0];
				default: ;  // drop writes to unmapped slots
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bbgp_pkg::REG_STEP_LENGTH:   prdata = {15'd0, cfg_q.step_length};
			bbgp_pkg::REG_STUTTER_LOOP:  prdata = {15'd0, cfg_q.stutter_loop};
			bbgp_pkg::REG_GATE_CHOP:     prdata = {15'd0, cfg_q.gate_chop};
			bbgp_pkg::REG_GATE_DUTY:     prdata = {15'd0, cfg_q.gate_duty};
			bbgp_pkg::REG_ECHO_DELAY:    prdata = {15'd0, cfg_q.echo_delay};
			bbgp_pkg::REG_ECHO_FEEDBACK: prdata = {17'd0, cfg_q.echo_feedback};
			bbgp_pkg::REG_STRETCH_RATE:  prdata = {16'd0, cfg_q.stretch_rate};
			default:                     prdata = '0;
		endcase
	end

	// sequencer: walks one sample through prep, remainder wait if needed, reads, multiply and result load
	bbgp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// capture memory, pointers and effect arithmetic
	bbgp_dp #(
		.CAPTURE_DEPTH (CAPTURE_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg_q),
		.in_left     (s_tdata[SB-1:0]),
		.in_right    (s_tdata[2*SB-1:SB]),
		.in_new_step (s_tuser[0]),
		.in_effect   (s_tuser[3:1]),
		.out_left    (out_l),
		.out_right   (out_r)
	);

	assign m_tdata = TDW'({out_r, out_l});

endmodule

@@ rtl/bbgp_div.sv @@
`timescale 1ns / 1ps
module bbgp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bbgp_pkg::POS_W-1:0]   dividend,
	input  logic [bbgp_pkg::LEN_W-1:0]   divisor,
	output logic                         done,
	output logic [bbgp_pkg::LEN_W-1:0]   remainder
);
	localparam int PW = bbgp_pkg::POS_W;
	localparam int LW = bbgp_pkg::LEN_W;
	localparam int CW = $clog2(PW + 1);

	logic [LW-1:0] rem_q;
	logic [PW-1:0] dvd_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [LW:0]   trial;
	logic [LW:0]   diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[PW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(PW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= (trial >= {1'b0, divisor}) ? diff[LW-1:0] : trial[LW-1:0];
			dvd_q <= {dvd_q[PW-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/bbgp_dp.sv @@
`timescale 1ns / 1ps
module bbgp_dp #(
	parameter int CAPTURE_DEPTH = 262144,
	parameter int SAMPLE_BITS   = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bbgp_pkg::cmd_t             cmd,
	output bbgp_pkg::sts_t             sts,
	input  bbgp_pkg::cfg_t             cfg,
	input  logic [SAMPLE_BITS-1:0]     in_left,
	input  logic [SAMPLE_BITS-1:0]     in_right,
	input  logic                       in_new_step,
	input  logic [bbgp_pkg::EFF_W-1:0] in_effect,
	output logic [SAMPLE_BITS-1:0]     out_left,
	output logic [SAMPLE_BITS-1:0]     out_right
);
	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = $clog2(CAPTURE_DEPTH);
	localparam int PW  = bbgp_pkg::POS_W;
	localparam int LW  = bbgp_pkg::LEN_W;
	localparam int RW  = bbgp_pkg::RATE_W;
	localparam int GW  = bbgp_pkg::GAIN_W + bbgp_pkg::FB_W;
	localparam int MW  = SB + RW + 2;
	localparam int DW  = SB + bbgp_pkg::GAIN_W + 1;
	localparam int WW  = SB + GW + 1;
	localparam int AC  = SB + 33;
	localparam int XW  = SB + 3;
	localparam logic signed [XW-1:0] SMAX = {4'b0000, {(SB-1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = {4'b1111, {(SB-1){1'b0}}};

	logic [SB-1:0] mem_l [CAPTURE_DEPTH];
	logic [SB-1:0] mem_r [CAPTURE_DEPTH];

	logic [AW-1:0]              wp_q;
	logic [AW-1:0]              start_q;
	logic                       filled_q;
	logic [PW-1:0]              play_q;
	logic [PW-1:0]              pos_q;
	logic [bbgp_pkg::EFF_W-1:0] eff_q;
	logic [SB-1:0]              lin_q, rin_q;
	logic [PW+RW-1:0]           p_q;
	logic [GW-1:0]              g_q;
	logic [SB-1:0]              rd_l_q, rd_r_q;
	logic                       rvalid_q;
	logic signed [SB-1:0]       v0_l_q, v0_r_q, v1_l_q, v1_r_q;
	logic signed [MW-1:0]       prod_l_q, prod_r_q;
	logic signed [DW-1:0]       dry_l_q, dry_r_q;
	logic signed [WW-1:0]       wet_l_q, wet_r_q;
	logic [SB-1:0]              out_l_q, out_r_q;

	logic [LW-1:0]   ssl, stut1, chop1, duty1, rem, divisor;
	logic [PW-1:0]   i0;
	logic [RW-1:0]   frac;
	logic [PW:0]     off0, off1, off, i0p1, sslm1;
	logic [AW-1:0]   raddr;
	logic            wet_ok;
	logic            rvalid_d;
	logic            div_done;
	logic            gate_open;
	logic signed [SB:0] d_l, d_r;
	logic [SB-1:0]   res_l, res_r;

	assign ssl   = (cfg.step_length  == '0) ? LW'(1) : cfg.step_length;
	assign stut1 = (cfg.stutter_loop == '0) ? LW'(1) : cfg.stutter_loop;
	assign chop1 = (cfg.gate_chop    == '0) ? LW'(1) : cfg.gate_chop;
	assign duty1 = (cfg.gate_duty    == '0) ? LW'(1) : cfg.gate_duty;

	assign sts.need_div = (eff_q == bbgp_pkg::EFF_STUTTER) || (eff_q == bbgp_pkg::EFF_GATE);
	assign sts.div_done = div_done;
	assign divisor = (eff_q == bbgp_pkg::EFF_GATE) ? chop1 : stut1;

	bbgp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (pos_q),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (rem)
	);

	// capture write and pointers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem_l[wp_q] <= in_left;
			mem_r[wp_q] <= in_right;
		end
		rd_l_q <= mem_l[raddr];
		rd_r_q <= mem_r[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			start_q  <= '0;
			filled_q <= 1'b0;
			play_q   <= '0;
		end else if (cmd.accept) begin
			wp_q <= wp_q + 1'b1;
			if (&wp_q)
				filled_q <= 1'b1;
			if (in_new_step) begin
				start_q <= wp_q - AW'(ssl);
				play_q  <= PW'(1);
			end else begin
				play_q <= play_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q <= in_new_step ? '0 : play_q;
			eff_q <= in_effect;
			lin_q <= in_left;
			rin_q <= in_right;
		end
		if (cmd.prep) begin
			p_q <= pos_q * cfg.stretch_rate;
			g_q <= cfg.echo_feedback * bbgp_pkg::GAIN_WET;
		end
	end

	// read offsets within the step
	assign i0     = p_q[PW+RW-1:RW];
	assign frac   = p_q[RW-1:0];
	assign i0p1   = {1'b0, i0} + 1'b1;
	assign sslm1  = {2'b00, ssl} - 1'b1;
	assign wet_ok = pos_q >= {1'b0, cfg.echo_delay};

	always_comb begin
		case (eff_q)
			bbgp_pkg::EFF_STUTTER: off0 = {2'b00, rem};
			bbgp_pkg::EFF_REVERSE:
				off0 = (pos_q < {1'b0, ssl}) ? (sslm1 - {1'b0, pos_q}) : '0;
			bbgp_pkg::EFF_STRETCH: off0 = {1'b0, i0};
			bbgp_pkg::EFF_GATE,
			bbgp_pkg::EFF_ECHO:    off0 = {1'b0, pos_q};
			default:               off0 = '0;
		endcase
		case (eff_q)
			bbgp_pkg::EFF_STRETCH: off1 = (i0p1 < sslm1) ? i0p1 : sslm1;
			bbgp_pkg::EFF_ECHO:    off1 = {1'b0, pos_q - {1'b0, cfg.echo_delay}};
			default:               off1 = off0;
		endcase
	end

	assign off   = cmd.rd_sel ? off1 : off0;
	assign raddr = start_q + AW'(off);
	// entries beyond the fill mark, and the echo tap before its delay, read as zero
	assign rvalid_d = (filled_q || (raddr < wp_q)) &&
		(!cmd.rd_sel || (eff_q != bbgp_pkg::EFF_ECHO) || wet_ok);

	always_ff @(posedge clk) begin
		rvalid_q <= rvalid_d;
		if (cmd.cap0) begin
			v0_l_q <= rvalid_q ? $signed(rd_l_q) : '0;
			v0_r_q <= rvalid_q ? $signed(rd_r_q) : '0;
		end
		if (cmd.cap1) begin
			v1_l_q <= rvalid_q ? $signed(rd_l_q) : '0;
			v1_r_q <= rvalid_q ? $signed(rd_r_q) : '0;
		end
	end

	assign d_l = (SB+1)'(v1_l_q) - (SB+1)'(v0_l_q);
	assign d_r = (SB+1)'(v1_r_q) - (SB+1)'(v0_r_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_l_q <= d_l * $signed({1'b0, frac});
			prod_r_q <= d_r * $signed({1'b0, frac});
			dry_l_q  <= v0_l_q * $signed({1'b0, bbgp_pkg::GAIN_DRY});
			dry_r_q  <= v0_r_q * $signed({1'b0, bbgp_pkg::GAIN_DRY});
			wet_l_q  <= v1_l_q * $signed({1'b0, g_q});
			wet_r_q  <= v1_r_q * $signed({1'b0, g_q});
		end
	end

	assign gate_open = rem < duty1;

	function automatic logic [SB-1:0] sat(input logic signed [XW-1:0] x);
		if (x > SMAX)
			sat = SMAX[SB-1:0];
		else if (x < SMIN)
			sat = SMIN[SB-1:0];
		else
			sat = x[SB-1:0];
	endfunction

	function automatic logic [SB-1:0] mix(
		input logic [bbgp_pkg::EFF_W-1:0] eff,
		input logic                       gate_op,
		input logic [SB-1:0]              dry_in,
		input logic signed [SB-1:0]       v0,
		input logic signed [MW-1:0]       prod,
		input logic signed [DW-1:0]       dry,
		input logic signed [WW-1:0]       wet
	);
		logic signed [MW-1:0] t;
		logic signed [XW-1:0] s;
		logic signed [AC-1:0] acc;
		t   = prod + MW'(32768);
		s   = XW'(t >>> 16) + XW'(v0);
		acc = (AC'(dry) <<< 15) + AC'(wet) + (AC'(1) <<< 29);
		case (eff)
			bbgp_pkg::EFF_STUTTER,
			bbgp_pkg::EFF_REVERSE: mix = v0;
			bbgp_pkg::EFF_STRETCH: mix = sat(s);
			bbgp_pkg::EFF_GATE:    mix = gate_op ? v0 : '0;
			bbgp_pkg::EFF_ECHO:    mix = sat(XW'(acc >>> 30));
			default:               mix = dry_in;
		endcase
	endfunction

	assign res_l = mix(eff_q, gate_open, lin_q, v0_l_q, prod_l_q, dry_l_q, wet_l_q);
	assign res_r = mix(eff_q, gate_open, rin_q, v0_r_q, prod_r_q, dry_r_q, wet_r_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_l_q <= res_l;
			out_r_q <= res_r;
		end
	end

	assign out_left  = out_l_q;
	assign out_right = out_r_q;

endmodule

@@ rtl/bbgp_ctrl.sv @@
`timescale 1ns / 1ps
module bbgp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output bbgp_pkg::cmd_t cmd,
	input  bbgp_pkg::sts_t sts
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD0  = 3'd3;
	localparam logic [2:0] ST_RD1  = 3'd4;
	localparam logic [2:0] ST_RD2  = 3'd5;
	localparam logic [2:0] ST_MUL  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       ovalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cmd.accept = s_tvalid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep      = 1'b1;
				cmd.div_start = sts.need_div;
				state_d       = sts.need_div ? ST_DIV : ST_RD0;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_RD0;
			end
			ST_RD0: begin
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_sel = 1'b1;
				cmd.cap0   = 1'b1;
				state_d    = ST_RD2;
			end
			ST_RD2: begin
				cmd.cap1 = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (!ovalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ovalid_q || m_tready))
		else $error("result overwrites an untaken result");
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_PREP))
		else $error("accepted sample not started");
	a_div_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider done flag stale after start");
	a_div_need: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> sts.need_div)
		else $error("divider wait without a modulo effect");
`endif

endmodule

@@ tb/sv/beat_buffer_glitch_player_test.sv @@
`timescale 1ns / 1ps
module beat_buffer_glitch_player_test;

	localparam int DEPTH = 262144;
	localparam int SB    = 24;
	localparam int DW    = ((2*SB+7)/8)*8;

	typedef struct {
		logic [SB-1:0] left;
		logic [SB-1:0] right;
		logic          new_step;
		logic [2:0]    effect;
	} sample_t;

	typedef struct {
		logic [SB-1:0] left;
		logic [SB-1:0] right;
	} stereo_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;   // left_in, right_in
	logic [3:0]    s_tuser;   // new_step, effect[2:0]
	logic          m_tvalid;
	logic          m_tready;
	logic [DW-1:0] m_tdata;   // left_out, right_out
	logic          psel, penable, pwrite;
	logic [4:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	beat_buffer_glitch_player dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: a private copy of the capture store and the settings.
	logic signed [SB-1:0] cap_l [DEPTH];
	logic signed [SB-1:0] cap_r [DEPTH];
	logic [bbgp_pkg::POS_W-1:0] wr_ptr, step_base, play_pos;
	bbgp_pkg::cfg_t cfg;

	sample_t pending_samples[$];
	stereo_t expected_out[$];

	int idle_in_pct, idle_out_pct;
	int mismatches, results_seen, sent;
	bit hold_input;
	int eff_count [8];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL beat_buffer_glitch_player");
		$finish;
	end

	function automatic longint unsigned nz(longint unsigned v);
		return v == 0 ? 1 : v;
	endfunction

	function automatic longint signed fetch(bit right, longint unsigned p);
		longint unsigned a;
		a = (step_base + p) % DEPTH;
		return right ? longint'(cap_r[a]) : longint'(cap_l[a]);
	endfunction

	function automatic longint signed sat24(longint signed v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// Floor division by a power of two; >>> on signed longint floors.
	function automatic longint signed effect_sample(bit right, logic [2:0] eff,
			longint signed dry_in, longint unsigned pos);
		longint unsigned len, p, i0, i1;
		longint signed f, v0, v1, dry, wet, acc;
		len = nz(cfg.step_length);
		case (eff)
			bbgp_pkg::EFF_STUTTER: return fetch(right, pos % nz(cfg.stutter_loop));
			bbgp_pkg::EFF_REVERSE: return fetch(right, pos < len ? len - 1 - pos : 0);
			bbgp_pkg::EFF_STRETCH: begin
				p = pos * cfg.stretch_rate;
				i0 = p >> 16;
				f = longint'(p & 64'hFFFF);
				i1 = (i0 + 1 < len - 1) ? i0 + 1 : len - 1;
				v0 = fetch(right, i0);
				v1 = fetch(right, i1);
				return v0 + (((v1 - v0) * f + 32768) >>> 16);
			end
			bbgp_pkg::EFF_GATE: begin
				if (pos % nz(cfg.gate_chop) < nz(cfg.gate_duty)) return fetch(right, pos);
				return 0;
			end
			bbgp_pkg::EFF_ECHO: begin
				dry = fetch(right, pos);
				wet = (pos >= cfg.echo_delay) ? fetch(right, pos - cfg.echo_delay) : 0;
				acc = dry * longint'(bbgp_pkg::GAIN_DRY) * 32768 +
					wet * longint'(cfg.echo_feedback) * longint'(bbgp_pkg::GAIN_WET);
				return sat24((acc + (64'sd1 << 29)) >>> 30);
			end
			default: return dry_in;
		endcase
	endfunction

	// Advance the predictor by one accepted sample and queue its output.
	task automatic predict_glitch(sample_t s);
		stereo_t o;
		longint unsigned pos;
		if (s.new_step) begin
			play_pos = '0;
			step_base = bbgp_pkg::POS_W'((wr_ptr + DEPTH - (nz(cfg.step_length) % DEPTH))
				% DEPTH);
		end
		cap_l[wr_ptr] = s.left;
		cap_r[wr_ptr] = s.right;
		wr_ptr = wr_ptr + 1'b1;
		pos = play_pos;
		o.left  = SB'(sat24(effect_sample(0, s.effect, longint'($signed(s.left)), pos)));
		o.right = SB'(sat24(effect_sample(1, s.effect, longint'($signed(s.right)), pos)));
		play_pos = play_pos + 1'b1;
		expected_out.insert(expected_out.size(), o);
		eff_count[s.effect]++;
	endtask

	// Driver: pull from the pending queue, idle at random between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_glitch(pending_samples.pop_front());
				sent++;
			end
			if ((!s_tvalid || s_tready) ) begin
				if (pending_samples.size() != 0 && !hold_input &&
						$urandom_range(99) >= idle_in_pct) begin
					s_tvalid <= 1;
					s_tdata  <= {pending_samples[0].right, pending_samples[0].left};
					s_tuser  <= {pending_samples[0].effect, pending_samples[0].new_step};
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Monitor: compare each output transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output transfer %h", m_tdata);
				end else begin
					stereo_t e;
					e = expected_out.pop_front();
					if (m_tdata[SB-1:0] !== e.left || m_tdata[2*SB-1:SB] !== e.right) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: expected L %h R %h, got L %h R %h",
								results_seen, e.left, e.right,
								m_tdata[SB-1:0], m_tdata[2*SB-1:SB]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= idle_out_pct);
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			bbgp_pkg::REG_STEP_LENGTH:   cfg.step_length   = val[bbgp_pkg::LEN_W-1:0];
			bbgp_pkg::REG_STUTTER_LOOP:  cfg.stutter_loop  = val[bbgp_pkg::LEN_W-1:0];
			bbgp_pkg::REG_GATE_CHOP:     cfg.gate_chop     = val[bbgp_pkg::LEN_W-1:0];
			bbgp_pkg::REG_GATE_DUTY:     cfg.gate_duty     = val[bbgp_pkg::LEN_W-1:0];
			bbgp_pkg::REG_ECHO_DELAY:    cfg.echo_delay    = val[bbgp_pkg::LEN_W-1:0];
			bbgp_pkg::REG_ECHO_FEEDBACK: cfg.echo_feedback = val[bbgp_pkg::FB_W-1:0];
			bbgp_pkg::REG_STRETCH_RATE:  cfg.stretch_rate  = val[bbgp_pkg::RATE_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every queued sample has gone through and the block is quiet.
	task automatic drain();
		int n;
		n = 0;
		while ((pending_samples.size() != 0 || s_tvalid || expected_out.size() != 0)
				&& n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic set_all(int sl, int su, int gc, int gd, int ed, int fb, int sr);
		apb_write(bbgp_pkg::REG_STEP_LENGTH, sl);
		apb_write(bbgp_pkg::REG_STUTTER_LOOP, su);
		apb_write(bbgp_pkg::REG_GATE_CHOP, gc);
		apb_write(bbgp_pkg::REG_GATE_DUTY, gd);
		apb_write(bbgp_pkg::REG_ECHO_DELAY, ed);
		apb_write(bbgp_pkg::REG_ECHO_FEEDBACK, fb);
		apb_write(bbgp_pkg::REG_STRETCH_RATE, sr);
	endtask

	function automatic logic [SB-1:0] rnd_sample();
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return SB'($urandom);
		endcase
	endfunction

	// Beat-shaped traffic: a step flag, then a run of samples, mostly with one effect and no flag.
	task automatic queue_beats(int count, int max_run);
		sample_t s;
		int run;
		logic [2:0] eff;
		while (count > 0) begin
			run = $urandom_range(max_run, 1);
			eff = 3'($urandom_range(7));
			for (int k = 0; k < run && count > 0; k++) begin
				s.left = rnd_sample();
				s.right = rnd_sample();
				s.new_step = (k == 0) || ($urandom_range(40) == 0);
				s.effect = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : eff;
				pending_samples.insert(pending_samples.size(), s);
				count--;
			end
		end
	endtask

	initial begin
		sample_t s;
		int n;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		wr_ptr = 0; step_base = 0; play_pos = 0;
		cfg.step_length = bbgp_pkg::RST_STEP_LENGTH;
		cfg.stutter_loop = bbgp_pkg::RST_STUTTER_LOOP;
		cfg.gate_chop = bbgp_pkg::RST_GATE_CHOP;
		cfg.gate_duty = bbgp_pkg::RST_GATE_DUTY;
		cfg.echo_delay = bbgp_pkg::RST_ECHO_DELAY;
		cfg.echo_feedback = bbgp_pkg::RST_ECHO_FEEDBACK;
		cfg.stretch_rate = bbgp_pkg::RST_STRETCH_RATE;
		for (int i = 0; i < DEPTH; i++) begin
			cap_l[i] = '0;
			cap_r[i] = '0;
		end
		mismatches = 0; results_seen = 0; sent = 0; hold_input = 0;
		idle_in_pct = 27; idle_out_pct = 64;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset settings, extremes, every effect code incl. unused 6 and 7.
		for (int e = 0; e < 8; e++) begin
			s.left = (e & 1) ? 24'h7FFFFF : 24'h800000;
			s.right = (e & 1) ? 24'h800000 : 24'h7FFFFF;
			s.new_step = (e == 0 || e == 4);
			s.effect = 3'(e);
			pending_samples.insert(pending_samples.size(), s);
		end
		drain();
		// Short step so the replay reaches real captured data; zero lengths act as one.
		set_all(8, 0, 0, 0, 2, 32767, 65535);
		queue_beats(16, 8);
		drain();

		// Random phase one, small lengths.
		set_all(16, 5, 4, 2, 3, 19661, 40000);
		queue_beats(300, 40);
		// Hold the sender mid-stream until everything is back, then resume.
		n = 0;
		while (sent < 170 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		hold_input = 1;
		n = 0;
		while ((s_tvalid || expected_out.size() != 0) && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
		hold_input = 0;
		drain();

		// Phase two: swap idling, top extremes on lengths, zero feedback and rate.
		idle_in_pct = 64; idle_out_pct = 27;
		set_all(131071, 131071, 131071, 131071, 131071, 0, 0);
		queue_beats(300, 40);
		drain();

		// Phase three: no idling, mid settings and random register values.
		idle_in_pct = 0; idle_out_pct = 0;
		set_all($urandom_range(64, 1), $urandom_range(20, 1), $urandom_range(12, 1),
			$urandom_range(12), $urandom_range(30, 1), $urandom_range(32767),
			$urandom_range(65535));
		queue_beats(300, 60);
		drain();
		set_all(3, 1, 1, 1, 1, 32767, 32768);
		queue_beats(300, 20);
		drain();

		if (expected_out.size() != 0) begin
			$display("%0d outputs never arrived", expected_out.size());
			mismatches++;
		end
		$display("covered %0d samples, %0d outputs checked over six register settings",
			sent, results_seen);
		$display("effects used: byp %0d stut %0d rev %0d str %0d gate %0d echo %0d unused %0d",
			eff_count[0], eff_count[1], eff_count[2], eff_count[3], eff_count[4],
			eff_count[5], eff_count[6] + eff_count[7]);
		if (mismatches == 0) begin
			$display("PASS beat_buffer_glitch_player");
		end else begin
			$display("FAIL beat_buffer_glitch_player");
		end
		$finish;
	end

endmodule
